[rtl/round_robin_unit_quantum_scheduler_unit_assert.svh]
// Assertion macros for the round-robin scheduler.
// Each macro checks a property on the rising clock edge, disabled while reset is low.
`ifndef ROUND_ROBIN_UNIT_QUANTUM_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_UNIT_QUANTUM_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define RRQS_ASSERT_IMP(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("scheduler check failed");

// Next-cycle implication
`define RRQS_ASSERT_NXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("scheduler check failed");

`else

`define RRQS_ASSERT_IMP(label, clk, rst_n, cond, expr)
`define RRQS_ASSERT_NXT(label, clk, rst_n, cond, expr)

`endif

`endif

[rtl/rrqs_pkg.sv]
package rrqs_pkg;

    // Field widths fixed by the stream format
    localparam int ID_FIELD_W = 8;
    localparam int BURST_W    = 16;
    localparam int SLOT_W     = 32;
    localparam int STATUS_W   = 3;

    // Item kinds on the input side
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_IDLE     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_RAN      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FINISHED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 3'd4;

    // One result item
    typedef struct packed {
        logic [BURST_W-1:0]    time_left;
        logic [SLOT_W-1:0]     slot_number;
        logic [ID_FIELD_W-1:0] run_id;
        logic [STATUS_W-1:0]   status;
    } result_t;

endpackage

[rtl/round_robin_unit_quantum_scheduler_unit.sv]
// A result is registered into the output register, or into the skid entry while the master side stalls.
// Throughput: 1 item per cycle while the skid entry is empty; the ready queue is read ahead into a head register
// so a tick never waits on the queue memory port.
// A two-entry output (result register plus skid entry): s_tready drops only once both hold an item.
// Reset (rst_n low, asynchronous): queue empty, slot counter zero, no results pending.
// Queue memory contents are not cleared.
`include "round_robin_unit_quantum_scheduler_unit_assert.svh"

module round_robin_unit_quantum_scheduler_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] process_id, [23:8] burst_time
    input  logic        s_tuser,   // [0] op
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] run_id, [39:8] slot_number, [55:40] time_left
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_BITS + rrqs_pkg::BURST_W;

    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_COUNT = OCC_W'(QUEUE_DEPTH);

    // Queue storage and control
    logic [ENTRY_W-1:0] queue_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] head_data_reg;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [rrqs_pkg::SLOT_W-1:0] slot_reg, slot_next;

    // Output register and skid entry
    rrqs_pkg::result_t out_reg, skid_reg, result;
    logic out_valid_reg, skid_valid_reg;

    logic               accept;
    logic               push_en;
    logic [ENTRY_W-1:0] push_data;
    logic [PTR_W-1:0]   head_inc, tail_inc;
    logic [15:0]        arr_id_wide;
    logic [ID_BITS-1:0] arr_id;
    logic [rrqs_pkg::BURST_W-1:0] arr_burst;
    logic [ID_BITS-1:0] head_id;
    logic [rrqs_pkg::BURST_W-1:0] head_time, dec_time;
    logic [15:0]        head_id_ext, arr_id_ext;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Input fields and head entry
    assign arr_id_wide = {8'b0, s_tdata[7:0]};
    assign arr_id      = arr_id_wide[ID_BITS-1:0];
    assign arr_burst   = s_tdata[23:8];
    assign head_id     = head_data_reg[ENTRY_W-1:rrqs_pkg::BURST_W];
    assign head_time   = head_data_reg[rrqs_pkg::BURST_W-1:0];
    assign dec_time    = head_time - 16'd1;
    assign head_id_ext = 16'(head_id);
    assign arr_id_ext  = 16'(arr_id);

    // Wrapping pointer increments
    assign head_inc = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc = (tail_reg == LAST_PTR) ? '0 : tail_reg + PTR_W'(1);

    // Scheduling decision for the accepted item
    always_comb
    begin
        push_en            = 1'b0;
        push_data          = '0;
        head_next          = head_reg;
        tail_next          = tail_reg;
        occ_next           = occ_reg;
        slot_next          = slot_reg;
        result.status      = rrqs_pkg::STATUS_IDLE;
        result.run_id      = '0;
        result.slot_number = slot_reg;
        result.time_left   = '0;
        if (accept)
        begin
            if (s_tuser == rrqs_pkg::OP_ARRIVAL)
            begin
                result.run_id    = arr_id_ext[7:0];
                result.time_left = arr_burst;
                if (arr_burst == '0 || occ_reg == FULL_COUNT)
                begin
                    result.status = rrqs_pkg::STATUS_DROPPED;
                end
                else
                begin
                    result.status = rrqs_pkg::STATUS_ACCEPTED;
                    push_en       = 1'b1;
                    push_data     = {arr_id, arr_burst};
                    tail_next     = tail_inc;
                    occ_next      = occ_reg + OCC_W'(1);
                end
            end
            else
            begin
                slot_next = slot_reg + 32'd1;
                if (occ_reg != '0)
                begin
                    result.run_id    = head_id_ext[7:0];
                    result.time_left = dec_time;
                    head_next        = head_inc;
                    if (dec_time == '0)
                    begin
                        result.status = rrqs_pkg::STATUS_FINISHED;
                        occ_next      = occ_reg - OCC_W'(1);
                    end
                    else
                    begin
                        // back to the tail; the pop just freed a place
                        result.status = rrqs_pkg::STATUS_RAN;
                        push_en       = 1'b1;
                        push_data     = {head_id, dec_time};
                        tail_next     = tail_inc;
                    end
                end
            end
        end
    end

    // Queue memory with read-ahead of the next head, write forwarded on collision
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            queue_mem[tail_reg] <= push_data;
        end
        if (push_en && tail_reg == head_next)
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= queue_mem[head_next];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= '0;
            slot_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
            slot_reg <= slot_next;
            if (!out_valid_reg || m_tready)
            begin
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.time_left, out_reg.slot_number, out_reg.run_id};

    // Checks
    `RRQS_ASSERT_IMP(occ_in_range, clk, rst_n, 1'b1, occ_reg <= FULL_COUNT)
    `RRQS_ASSERT_IMP(skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `RRQS_ASSERT_NXT(tick_advances_slot, clk, rst_n,
        accept && s_tuser == rrqs_pkg::OP_TICK,
        slot_reg == $past(slot_reg) + 32'd1)
    `RRQS_ASSERT_NXT(full_drop_keeps_queue, clk, rst_n,
        accept && s_tuser == rrqs_pkg::OP_ARRIVAL && occ_reg == FULL_COUNT,
        $stable(occ_reg) && $stable(tail_reg))

endmodule
